// ----- sv/analog_keypad_scan_debounce_assert.svh -----
// Assertion macros for the keypad scanner RTL; included by akpd_scan.
// Depends on nothing; the checks compile out when SYNTHESIS is defined.
`ifndef ANALOG_KEYPAD_SCAN_DEBOUNCE_ASSERT_SVH
`define ANALOG_KEYPAD_SCAN_DEBOUNCE_ASSERT_SVH

`ifndef SYNTHESIS
`define AKPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AKPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AKPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define AKPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/akpd_pkg.sv -----
// Types and constants for the analog keypad scanner.
// Used by the interfaces and all modules of the block.
`default_nettype none

package akpd_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int STABLE_W    = 4;
    localparam int ROW_W       = 2;
    localparam int KCOL_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int COLUMNS_DEF = 4;

    localparam logic [SAMPLE_W-1:0] ROW0_TH_RST = SAMPLE_W'(800);
    localparam logic [SAMPLE_W-1:0] ROW1_TH_RST = SAMPLE_W'(450);
    localparam logic [SAMPLE_W-1:0] ROW2_TH_RST = SAMPLE_W'(320);
    localparam logic [SAMPLE_W-1:0] ROW3_TH_RST = SAMPLE_W'(50);
    localparam logic [STABLE_W-1:0] STABLE_RST  = STABLE_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_TH = 3'd0,
        CFG_ROW1_TH = 3'd1,
        CFG_ROW2_TH = 3'd2,
        CFG_ROW3_TH = 3'd3,
        CFG_STABLE  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] row0_th;
        logic [SAMPLE_W-1:0] row1_th;
        logic [SAMPLE_W-1:0] row2_th;
        logic [SAMPLE_W-1:0] row3_th;
        logic [STABLE_W-1:0] stable_reads;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
    } t_class;

    typedef struct packed {
        logic              shift_bit;
        logic              key_valid;
        logic [ROW_W-1:0]  key_row;
        logic [KCOL_W-1:0] key_col;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/akpd_in_if.sv -----
// Sample channel of the keypad scanner: valid/ready plus the converter sample.
// Depends on akpd_pkg.
`default_nettype none

interface akpd_in_if;
    logic                          valid;
    logic                          ready;
    logic [akpd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- sv/akpd_out_if.sv -----
// Result channel of the keypad scanner: valid/ready plus shift bit and key report.
// Depends on akpd_pkg.
`default_nettype none

interface akpd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        shift_bit;
    logic                        key_valid;
    logic [akpd_pkg::ROW_W-1:0]  key_row;
    logic [akpd_pkg::KCOL_W-1:0] key_col;

    modport source (output valid, output shift_bit, output key_valid, output key_row,
                    output key_col, input ready);
    modport sink   (input valid, input shift_bit, input key_valid, input key_row,
                    input key_col, output ready);
endinterface

`default_nettype wire

// ----- sv/akpd_cfg_regs.sv -----
// Configuration registers: row thresholds and debounce count.
// Depends on akpd_pkg.
`default_nettype none

module akpd_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [akpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [akpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output      akpd_pkg::t_cfg                  o_cfg
);
    import akpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row0_th      <= ROW0_TH_RST;
            r_cfg.row1_th      <= ROW1_TH_RST;
            r_cfg.row2_th      <= ROW2_TH_RST;
            r_cfg.row3_th      <= ROW3_TH_RST;
            r_cfg.stable_reads <= STABLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW0_TH: r_cfg.row0_th      <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ROW1_TH: r_cfg.row1_th      <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ROW2_TH: r_cfg.row2_th      <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ROW3_TH: r_cfg.row3_th      <= i_cfg_data[SAMPLE_W-1:0];
                CFG_STABLE:  r_cfg.stable_reads <= i_cfg_data[STABLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

`default_nettype wire

// ----- sv/akpd_classify.sv -----
// Row classifier: compares one sample against the thresholds in falling order.
// Depends on akpd_pkg.
`default_nettype none

module akpd_classify (
    input  wire logic [akpd_pkg::SAMPLE_W-1:0] i_sample,
    input  wire akpd_pkg::t_cfg                i_cfg,
    output      akpd_pkg::t_class              o_class
);
    import akpd_pkg::*;

    always_comb begin
        o_class = '{hit: 1'b1, row: ROW_W'(0)};
        if (i_sample > i_cfg.row0_th) begin
            o_class.row = ROW_W'(0);
        end else if (i_sample > i_cfg.row1_th) begin
            o_class.row = ROW_W'(1);
        end else if (i_sample > i_cfg.row2_th) begin
            o_class.row = ROW_W'(2);
        end else if (i_sample > i_cfg.row3_th) begin
            o_class.row = ROW_W'(3);
        end else begin
            o_class.hit = 1'b0;
        end
    end
endmodule

`default_nettype wire

// ----- sv/akpd_scan.sv -----
// Column sequencing and scan debounce: holds strobe position and last scan result.
// Depends on akpd_pkg and the assertion macro header.
`default_nettype none
`include "analog_keypad_scan_debounce_assert.svh"

module akpd_scan #(
    parameter int COLUMNS = akpd_pkg::COLUMNS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire akpd_pkg::t_class               i_class,
    input  wire logic [akpd_pkg::STABLE_W-1:0]  i_stable_reads,
    output      akpd_pkg::t_result              o_res
);
    import akpd_pkg::*;

    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int KW = (CW > KCOL_W) ? CW : KCOL_W;
    localparam logic [CW-1:0]       LAST_POS  = CW'(COLUMNS - 1);
    localparam logic [STABLE_W-1:0] MATCH_MAX = '1;

    logic [CW-1:0]       r_col_idx, n_col_idx;
    logic                r_prev_none, n_prev_none;
    logic [ROW_W-1:0]    r_prev_row, n_prev_row;
    logic [CW-1:0]       r_prev_col, n_prev_col;
    logic [STABLE_W-1:0] r_match, n_match;
    logic                r_reported, n_reported;

    logic                last, same, report, reported_base;
    logic [CW-1:0]       col, col_e;
    logic [ROW_W-1:0]    row_e;
    logic [KW-1:0]       col_ext;

    always_comb begin
        last          = i_class.hit || (r_col_idx == LAST_POS);
        col           = LAST_POS - r_col_idx;
        row_e         = i_class.hit ? i_class.row : '0;
        col_e         = i_class.hit ? col : '0;
        same          = (!i_class.hit == r_prev_none)
                        && (!i_class.hit || (row_e == r_prev_row && col_e == r_prev_col));
        n_match       = same ? ((r_match == MATCH_MAX) ? r_match : r_match + 1'b1) : '0;
        reported_base = same && r_reported;
        report        = last && i_class.hit && !reported_base && (n_match >= i_stable_reads);
        n_reported    = reported_base || report;
        n_prev_none   = !i_class.hit;
        n_prev_row    = row_e;
        n_prev_col    = col_e;
        n_col_idx     = last ? '0 : r_col_idx + 1'b1;
        col_ext       = KW'(col);

        o_res.shift_bit = last;
        o_res.key_valid = report;
        o_res.key_row   = report ? i_class.row : '0;
        o_res.key_col   = report ? col_ext[KCOL_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx   <= '0;
            r_prev_none <= 1'b1;
            r_prev_row  <= '0;
            r_prev_col  <= '0;
            r_match     <= '0;
            r_reported  <= 1'b0;
        end else if (i_step) begin
            r_col_idx <= n_col_idx;
            if (last) begin
                r_match    <= n_match;
                r_reported <= n_reported;
                if (!same) begin
                    r_prev_none <= n_prev_none;
                    r_prev_row  <= n_prev_row;
                    r_prev_col  <= n_prev_col;
                end
            end
        end
    end

    `AKPD_ASSERT_IMP(a_col_idx_range, i_clk, i_rst_n, 1'b1, r_col_idx <= LAST_POS,
        "strobe position past last column")
    `AKPD_ASSERT_IMP(a_report_ends_scan, i_clk, i_rst_n, o_res.key_valid,
        o_res.shift_bit && i_class.hit, "key reported without a completed hit")
    `AKPD_ASSERT_NXT(a_report_latched, i_clk, i_rst_n, i_step && report,
        r_reported && !r_prev_none && r_col_idx == '0, "report not latched")
    `AKPD_ASSERT_IMP(a_none_no_report, i_clk, i_rst_n, r_prev_none, !r_reported,
        "no-key scan marked reported")
endmodule

`default_nettype wire

// ----- sv/analog_keypad_scan_debounce.sv -----
// Resistor-ladder keypad scanner with debounce: sample register, classify, result register.
// One sample a cycle when the result side keeps up. A sample passes through the input
// register, then the output register, where its result is presented; the move between
// them waits while the result side is stalled. Scan state advances as each sample moves
// into the output register. Thresholds and the debounce count are for the user to write
// through the plain configuration port only while idle; the block does not enforce this.
// Depends on akpd_pkg, akpd_in_if, akpd_out_if, akpd_cfg_regs, akpd_classify, akpd_scan.
`default_nettype none

module analog_keypad_scan_debounce #(
    parameter int COLUMNS = akpd_pkg::COLUMNS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [akpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [akpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    akpd_in_if.sink                              i_in,
    akpd_out_if.source                           o_out
);
    import akpd_pkg::*;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    t_result             r_out;

    t_cfg    cfg;
    t_class  cls;
    t_result res;
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    akpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    akpd_classify u_classify (
        .i_sample (r_in_sample),
        .i_cfg    (cfg),
        .o_class  (cls)
    );

    akpd_scan #(
        .COLUMNS (COLUMNS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_class        (cls),
        .i_stable_reads (cfg.stable_reads),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_sample <= i_in.sample;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.shift_bit = r_out.shift_bit;
    assign o_out.key_valid = r_out.key_valid;
    assign o_out.key_row   = r_out.key_row;
    assign o_out.key_col   = r_out.key_col;
endmodule

`default_nettype wire
